/* rtl/ale_pkg.sv */
// shared types and constants of the array list engine
`default_nettype none

package ale_pkg;

   localparam int OP_W     = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 4;
   localparam int ECOUNT_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INS_AT    = 3'd0,
      OP_INS_FRONT = 3'd1,
      OP_REMOVE    = 3'd2,
      OP_SORTED    = 3'd3,
      OP_SEARCH    = 3'd4,
      OP_READ      = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_RANGE     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   // what the cells do in the current cycle
   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_INSERT = 3'd1,
      CELL_SORTED = 3'd2,
      CELL_REMOVE = 3'd3,
      CELL_SEARCH = 3'd4,
      CELL_READ   = 3'd5
   } cell_op_type;

   typedef struct packed {
      cell_op_type               kind;
      logic                      commit;
      logic [POS_W-1:0]          pos;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

   // first hit travelling up the chain
   typedef struct packed {
      logic                      hit;
      logic [FOUND_W-1:0]        idx;
      logic signed [VALUE_W-1:0] data;
   } link_type;

endpackage

`default_nettype wire

/* rtl/ale_if.sv */
// request and response channel interfaces
`default_nettype none

interface ale_req_if;
   import ale_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           operation;
   logic [POS_W-1:0]          position;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output operation, output position, output value,
                   input ready);
   modport sink   (input valid, input operation, input position, input value,
                   output ready);
endinterface

interface ale_rsp_if;
   import ale_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic [FOUND_W-1:0]        found_index;
   logic signed [VALUE_W-1:0] read_value;
   logic [ECOUNT_W-1:0]       entry_count;

   modport source (output valid, output status, output found_index, output read_value,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input found_index, input read_value,
                   input entry_count, output ready);
endinterface

`default_nettype wire

/* rtl/ale_cell.sv */
// one list cell: holds an entry, shifts with its neighbors, carries the scan waves
`default_nettype none

module ale_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                               clock,
   input  ale_pkg::cell_ctrl_type             ctrl,
   input  logic [CNT_W-1:0]                   count,
   input  logic signed [ale_pkg::VALUE_W-1:0] left_entry,
   input  logic signed [ale_pkg::VALUE_W-1:0] right_entry,
   input  logic                               below_shift,
   input  logic                               above_wave,
   input  ale_pkg::link_type                  link_below,
   output logic signed [ale_pkg::VALUE_W-1:0] entry_out,
   output logic                               wave_out,
   output logic                               wave_next,
   output ale_pkg::link_type                  link_out,
   output ale_pkg::link_type                  link_next
);
   import ale_pkg::*;

   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      wave_ff, wave_in;
   link_type                  link_ff, link_in;
   logic [CMP_W-1:0]          pos_e, cnt_e;
   logic                      below_cnt, greater, take_left, take_new, hit;

   assign pos_e     = CMP_W'(ctrl.pos);
   assign cnt_e     = CMP_W'(count);
   assign below_cnt = IDX < cnt_e;
   assign greater   = entry_ff > ctrl.value;

   // downward wave: this entry and every valid one above it exceed the value
   assign wave_in = !below_cnt || (greater && above_wave);

   always_comb begin
      if (ctrl.kind == CELL_SORTED) begin
         take_left = below_shift;
         take_new  = wave_in;
      end else begin
         take_left = IDX > pos_e;
         take_new  = IDX == pos_e;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.commit) begin
         case (ctrl.kind)
            CELL_INSERT, CELL_SORTED: begin
               if (take_left) begin
                  entry_in = left_entry;
               end else if (take_new) begin
                  entry_in = ctrl.value;
               end
            end
            CELL_REMOVE: begin
               if (IDX >= pos_e) begin
                  entry_in = right_entry;
               end
            end
            default: entry_in = entry_ff;
         endcase
      end
   end

   always_comb begin
      case (ctrl.kind)
         CELL_SEARCH: hit = below_cnt && (entry_ff == ctrl.value);
         CELL_READ:   hit = IDX == pos_e;
         default:     hit = 1'b0;
      endcase
   end

   // upward wave: the lowest hit wins
   always_comb begin
      if (link_below.hit) begin
         link_in = link_below;
      end else if (hit) begin
         link_in.hit  = 1'b1;
         link_in.idx  = FOUND_W'(INDEX);
         link_in.data = entry_ff;
      end else begin
         link_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      wave_ff  <= wave_in;
      link_ff  <= link_in;
   end

   assign entry_out = entry_ff;
   assign wave_out  = wave_ff;
   assign wave_next = wave_in;
   assign link_out  = link_ff;
   assign link_next = link_in;

endmodule

`default_nettype wire

/* rtl/array_list_engine_core.sv */
// array list engine top level: sequencer, count and a chain of list cells
// responses: insert at position, insert front, remove and any rejected request
//   give their response in the cycle after acceptance; search, read and sorted
//   insert first scan the cells in SEQ_SCAN and respond after its last step
// requests: one per cycle for the immediate operations while responses are taken;
//   no new request during a scan, whose waves ripple one cell per cycle
// reset (synchronous): clears the count, sequencer and response valid; entries undefined
`default_nettype none

module array_list_engine_core #(
   parameter int LIST_DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   ale_req_if.sink   req_bus,
   ale_rsp_if.source rsp_bus
);
   import ale_pkg::*;

   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int STEP_W = $clog2(LIST_DEPTH);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'b01,
      SEQ_SCAN = 2'b10
   } seq_state_type;

   seq_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   cell_op_type         held_kind_ff, held_kind_in;
   logic [POS_W-1:0]    held_pos_ff, held_pos_in;
   logic signed [VALUE_W-1:0] held_value_ff, held_value_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [FOUND_W-1:0]  rsp_found_ff, rsp_found_in;
   logic signed [VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                accept, full, pos_gt_cnt, pos_ge_cnt, last_step;
   logic                imm_commit, imm_scan;
   cell_op_type         imm_kind;
   logic [POS_W-1:0]    imm_pos;
   status_type          imm_status;
   cell_ctrl_type       ctrl;
   link_type            top_link;

   logic signed [VALUE_W-1:0] entry_w     [LIST_DEPTH];
   logic                      wave_w      [LIST_DEPTH];
   logic                      wave_next_w [LIST_DEPTH];
   link_type                  link_w      [LIST_DEPTH];
   link_type                  link_next_w [LIST_DEPTH];

   assign req_bus.ready = (state_ff == SEQ_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign full          = count_ff == CNT_W'(LIST_DEPTH);
   assign pos_gt_cnt    = CMP_W'(req_bus.position) > CMP_W'(count_ff);
   assign pos_ge_cnt    = CMP_W'(req_bus.position) >= CMP_W'(count_ff);
   assign last_step     = (state_ff == SEQ_SCAN) && (step_ff == '0);
   assign top_link      = link_next_w[LIST_DEPTH-1];

   // decode of the request at the input
   always_comb begin
      imm_commit = 1'b0;
      imm_scan   = 1'b0;
      imm_kind   = CELL_HOLD;
      imm_pos    = req_bus.position;
      imm_status = STAT_OK;
      case (op_type'(req_bus.operation))
         OP_INS_AT: begin
            if (full) begin
               imm_status = STAT_FULL;
            end else if (pos_gt_cnt) begin
               imm_status = STAT_RANGE;
            end else begin
               imm_commit = 1'b1;
               imm_kind   = CELL_INSERT;
            end
         end
         OP_INS_FRONT: begin
            if (full) begin
               imm_status = STAT_FULL;
            end else begin
               imm_commit = 1'b1;
               imm_kind   = CELL_INSERT;
               imm_pos    = '0;
            end
         end
         OP_REMOVE: begin
            if (pos_ge_cnt) begin
               imm_status = STAT_RANGE;
            end else begin
               imm_commit = 1'b1;
               imm_kind   = CELL_REMOVE;
            end
         end
         OP_SORTED: begin
            if (full) begin
               imm_status = STAT_FULL;
            end else begin
               imm_scan = 1'b1;
               imm_kind = CELL_SORTED;
            end
         end
         OP_SEARCH: begin
            imm_scan = 1'b1;
            imm_kind = CELL_SEARCH;
         end
         OP_READ: begin
            if (pos_ge_cnt) begin
               imm_status = STAT_RANGE;
            end else begin
               imm_scan = 1'b1;
               imm_kind = CELL_READ;
            end
         end
         default: imm_status = STAT_OK;
      endcase
   end

   always_comb begin
      if (state_ff == SEQ_SCAN) begin
         ctrl.kind   = held_kind_ff;
         ctrl.commit = last_step && (held_kind_ff == CELL_SORTED);
         ctrl.pos    = held_pos_ff;
         ctrl.value  = held_value_ff;
      end else begin
         ctrl.kind   = imm_kind;
         ctrl.commit = accept && imm_commit;
         ctrl.pos    = imm_pos;
         ctrl.value  = req_bus.value;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      held_kind_in  = held_kind_ff;
      held_pos_in   = held_pos_ff;
      held_value_in = held_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               if (imm_scan) begin
                  state_in      = SEQ_SCAN;
                  step_in       = STEP_W'(LIST_DEPTH - 1);
                  held_kind_in  = imm_kind;
                  held_pos_in   = req_bus.position;
                  held_value_in = req_bus.value;
               end else begin
                  if (imm_commit && (imm_kind == CELL_INSERT)) begin
                     count_in = count_ff + 1'b1;
                  end else if (imm_commit && (imm_kind == CELL_REMOVE)) begin
                     count_in = count_ff - 1'b1;
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = imm_status;
                  rsp_found_in  = '0;
                  rsp_data_in   = '0;
                  rsp_count_in  = count_in;
               end
            end
         end
         SEQ_SCAN: begin
            step_in = step_ff - 1'b1;
            if (last_step) begin
               state_in      = SEQ_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_found_in  = '0;
               rsp_data_in   = '0;
               case (held_kind_ff)
                  CELL_SORTED: count_in = count_ff + 1'b1;
                  CELL_SEARCH: begin
                     if (top_link.hit) begin
                        rsp_found_in = top_link.idx;
                     end else begin
                        rsp_status_in = STAT_NOT_FOUND;
                     end
                  end
                  CELL_READ: rsp_data_in = top_link.data;
                  default:   rsp_status_in = STAT_OK;
               endcase
               rsp_count_in = count_in;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_kind_ff  <= held_kind_in;
      held_pos_ff   <= held_pos_in;
      held_value_ff <= held_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.found_index = rsp_found_ff;
   assign rsp_bus.read_value  = rsp_data_ff;
   assign rsp_bus.entry_count = ECOUNT_W'(rsp_count_ff);

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_e, right_e;
      logic                      below_s, above_w;
      link_type                  below_l;

      if (i == 0) begin : g_bottom
         assign left_e  = entry_w[i];
         assign below_s = 1'b0;
         assign below_l = '0;
      end else begin : g_inner_lo
         assign left_e  = entry_w[i-1];
         assign below_s = wave_next_w[i-1];
         assign below_l = link_w[i-1];
      end

      if (i == LIST_DEPTH - 1) begin : g_top
         assign right_e = entry_w[i];
         assign above_w = 1'b1;
      end else begin : g_inner_hi
         assign right_e = entry_w[i+1];
         assign above_w = wave_w[i+1];
      end

      ale_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .left_entry  (left_e),
         .right_entry (right_e),
         .below_shift (below_s),
         .above_wave  (above_w),
         .link_below  (below_l),
         .entry_out   (entry_w[i]),
         .wave_out    (wave_w[i]),
         .wave_next   (wave_next_w[i]),
         .link_out    (link_w[i]),
         .link_next   (link_next_w[i])
      );
   end

   // count stays within the list depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LIST_DEPTH))
      else $error("entry count exceeds list depth");

   // the response slot is free for the whole scan
   a_scan_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_SCAN) |-> !rsp_valid_ff)
      else $error("response pending during scan");

   // an accepted insert grows the list by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (accept && imm_commit && (imm_kind == CELL_INSERT))
      |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("insert did not advance the count");

   // a rejected insert on a full list leaves the count alone
   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (accept && full && (imm_status == STAT_FULL)) |=> $stable(count_ff))
      else $error("rejected insert changed the count");

endmodule

`default_nettype wire

/* tb/sv/array_list_engine_checker.sv */
// checker for the array list engine: shadow list, expected response queue, field compare
`timescale 1ns / 100ps
`default_nettype none

module array_list_engine_checker #(
   parameter int LIST_DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   ale_req_if   req_mon,
   ale_rsp_if   rsp_mon,
   output int   fail_count,
   output int   outstanding
);
   import ale_pkg::*;

   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [FOUND_W-1:0]        found_index;
      logic signed [VALUE_W-1:0] read_value;
      logic [ECOUNT_W-1:0]       entry_count;
   } list_result_type;

   logic signed [VALUE_W-1:0] shadow_list [LIST_DEPTH];
   int                        shadow_count = 0;
   list_result_type           expected_responses [$];
   list_result_type           oldest;
   int                        errors = 0;

   function automatic void open_slot(input int at, input logic signed [VALUE_W-1:0] val);
      int i;
      for (i = shadow_count; i > at; i--)
         shadow_list[i] = shadow_list[i-1];
      shadow_list[at] = val;
      shadow_count++;
   endfunction

   // applies one request to the shadow list and returns the response it should give
   function automatic list_result_type apply_list_op(input logic [OP_W-1:0] op,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic signed [VALUE_W-1:0] val);
      list_result_type r;
      int              i;
      bit              full;
      r    = '0;
      full = (shadow_count >= LIST_DEPTH);
      case (op)
         OP_INS_AT: begin
            if (full) r.status = STAT_FULL;
            else if (int'(pos) > shadow_count) r.status = STAT_RANGE;
            else open_slot(int'(pos), val);
         end
         OP_INS_FRONT: begin
            if (full) r.status = STAT_FULL;
            else open_slot(0, val);
         end
         OP_REMOVE: begin
            if (int'(pos) >= shadow_count) r.status = STAT_RANGE;
            else begin
               for (i = int'(pos); i + 1 < shadow_count; i++)
                  shadow_list[i] = shadow_list[i+1];
               shadow_count--;
            end
         end
         OP_SORTED: begin
            if (full) r.status = STAT_FULL;
            else begin
               // goes after every entry not greater than the new value
               i = shadow_count;
               while (i > 0 && shadow_list[i-1] > val)
                  i--;
               open_slot(i, val);
            end
         end
         OP_SEARCH: begin
            r.status = STAT_NOT_FOUND;
            for (i = 0; i < shadow_count; i++) begin
               if (shadow_list[i] == val) begin
                  r.status      = STAT_OK;
                  r.found_index = i[FOUND_W-1:0];
                  break;
               end
            end
         end
         OP_READ: begin
            if (int'(pos) >= shadow_count) r.status = STAT_RANGE;
            else r.read_value = shadow_list[pos];
         end
         default: ;
      endcase
      r.entry_count = shadow_count[ECOUNT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                  input logic [31:0] act_v);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         expected_responses.delete();
      end else begin
         // responses first: responses are registered, so none answers a request of this same cycle
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_responses.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: response with no request pending, status %0h count %0h",
                           $time, rsp_mon.status, rsp_mon.entry_count);
            end else begin
               oldest = expected_responses.pop_front();
               if (rsp_mon.status !== oldest.status)
                  report_mismatch("status", 32'(oldest.status), 32'(rsp_mon.status));
               if (rsp_mon.found_index !== oldest.found_index)
                  report_mismatch("found_index", 32'(oldest.found_index),
                                  32'(rsp_mon.found_index));
               if (rsp_mon.read_value !== oldest.read_value)
                  report_mismatch("read_value", oldest.read_value, rsp_mon.read_value);
               if (rsp_mon.entry_count !== oldest.entry_count)
                  report_mismatch("entry_count", 32'(oldest.entry_count),
                                  32'(rsp_mon.entry_count));
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            expected_responses.push_back(apply_list_op(req_mon.operation, req_mon.position,
                                                       req_mon.value));
      end
      outstanding <= expected_responses.size();
      fail_count  <= errors;
   end

endmodule

`default_nettype wire

/* tb/sv/array_list_engine_core_tb.sv */
// testbench top of the array list engine: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps
`default_nettype none

module array_list_engine_core_tb;
   import ale_pkg::*;

   localparam int LIST_DEPTH      = 16;
   localparam int DRAIN_CYCLES    = 2 * LIST_DEPTH + 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int ITEMS_PER_PHASE = 395;

   localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

   localparam int MODE_FILL   = 0;
   localparam int MODE_DRAIN  = 1;
   localparam int MODE_SORTED = 2;
   localparam int MODE_MIXED  = 3;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   sender_idle_pct;
   int   receiver_idle_pct;
   bit   hold_off_request;
   bit   hold_off_done;

   ale_req_if req_bus ();
   ale_rsp_if rsp_bus ();

   array_list_engine_core #(.LIST_DEPTH(LIST_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   array_list_engine_checker #(.LIST_DEPTH(LIST_DEPTH)) list_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // response side: random back-pressure plus one long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && !hold_off_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic signed [VALUE_W-1:0] val);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.position  <= pos;
      req_bus.value     <= val;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(9);
      if (r < 4) return int'($urandom_range(8)) - 4;   // small pool: hits and duplicates
      if (r == 4) begin
         case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [POS_W-1:0] pick_position(input int span);
      if ($urandom_range(4) == 0) return POS_W'($urandom_range(31));
      return POS_W'($urandom_range(span));
   endfunction

   task automatic random_request(input int mode);
      int r;
      r = $urandom_range(99);
      if (r < 2) begin
         send_request($urandom_range(1) ? OP_UNUSED_7 : OP_UNUSED_6, POS_W'($urandom),
                      $urandom);
         return;
      end
      case (mode)
         MODE_FILL: begin
            if (r < 28)      send_request(OP_INS_AT, pick_position(LIST_DEPTH), pick_value());
            else if (r < 45) send_request(OP_INS_FRONT, pick_position(31), pick_value());
            else if (r < 72) send_request(OP_SORTED, pick_position(31), pick_value());
            else if (r < 82) send_request(OP_SEARCH, pick_position(31), pick_value());
            else if (r < 92) send_request(OP_READ, pick_position(LIST_DEPTH), pick_value());
            else             send_request(OP_REMOVE, pick_position(LIST_DEPTH), pick_value());
         end
         MODE_DRAIN: begin
            if (r < 52)      send_request(OP_REMOVE, pick_position(7), pick_value());
            else if (r < 67) send_request(OP_READ, pick_position(LIST_DEPTH), pick_value());
            else if (r < 82) send_request(OP_SEARCH, pick_position(31), pick_value());
            else             send_request(OP_INS_AT, pick_position(7), pick_value());
         end
         MODE_SORTED: begin
            if (r < 55)      send_request(OP_SORTED, pick_position(31), pick_value());
            else if (r < 78) send_request(OP_SEARCH, pick_position(31), pick_value());
            else if (r < 90) send_request(OP_READ, pick_position(LIST_DEPTH), pick_value());
            else             send_request(OP_REMOVE, pick_position(LIST_DEPTH), pick_value());
         end
         default: begin
            if (r < 18)      send_request(OP_INS_AT, pick_position(LIST_DEPTH), pick_value());
            else if (r < 32) send_request(OP_INS_FRONT, pick_position(31), pick_value());
            else if (r < 50) send_request(OP_REMOVE, pick_position(LIST_DEPTH), pick_value());
            else if (r < 66) send_request(OP_SORTED, pick_position(31), pick_value());
            else if (r < 83) send_request(OP_SEARCH, pick_position(31), pick_value());
            else             send_request(OP_READ, pick_position(LIST_DEPTH), pick_value());
         end
      endcase
   endtask

   initial begin
      int phase;
      int issued;
      int run_len;
      int mode;
      int i;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_INS_AT;
      req_bus.position  = '0;
      req_bus.value     = '0;
      sender_idle_pct   = 15;
      receiver_idle_pct = 66;
      hold_off_request  = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list: everything out of range or missing
      send_request(OP_READ, 5'd0, 32'sd0);
      send_request(OP_REMOVE, 5'd0, 32'sd0);
      send_request(OP_SEARCH, 5'd0, 32'sd0);
      send_request(OP_INS_AT, 5'd1, 32'sd7);
      // extremes, equal values in sorted insert, append at the count
      send_request(OP_INS_AT, 5'd0, 32'sh8000_0000);
      send_request(OP_INS_FRONT, 5'd9, 32'sh7fff_ffff);
      send_request(OP_SORTED, 5'd0, 32'sd0);
      send_request(OP_SORTED, 5'd0, 32'sd0);
      send_request(OP_INS_AT, 5'd4, -32'sd1);
      send_request(OP_READ, 5'd4, 32'sd0);
      for (i = 0; i < LIST_DEPTH - 5; i++)
         send_request(OP_SORTED, 5'd0, 32'sd100 + i);
      // full list: full wins over a bad position
      send_request(OP_INS_AT, 5'd31, 32'sd1);
      send_request(OP_INS_FRONT, 5'd0, 32'sd1);
      send_request(OP_SORTED, 5'd0, 32'sd1);
      send_request(OP_READ, 5'd15, 32'sd0);
      send_request(OP_READ, 5'd16, 32'sd0);
      send_request(OP_SEARCH, 5'd0, 32'sd110);
      send_request(OP_SEARCH, 5'd0, 32'sd12345);
      send_request(OP_REMOVE, 5'd31, 32'sd0);
      send_request(OP_REMOVE, 5'd15, 32'sd0);
      send_request(OP_REMOVE, 5'd0, 32'sd0);
      send_request(OP_UNUSED_6, 5'd31, 32'shffff_ffff);
      send_request(OP_UNUSED_7, 5'd3, 32'sd5);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 15;
               receiver_idle_pct = 66;
            end
            1: begin
               sender_idle_pct   = 66;
               receiver_idle_pct = 15;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
               hold_off_request  = 1'b1;
            end
         endcase
         issued = 0;
         while (issued < ITEMS_PER_PHASE) begin
            mode    = $urandom_range(MODE_MIXED);
            run_len = $urandom_range(40, 8);
            repeat (run_len) begin
               random_request(mode);
               issued++;
            end
         end
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
